@@ rtl/core/repeating_key_additive_cipher_assert.svh @@
// Assertion macros used by the cipher top module.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef REPEATING_KEY_ADDITIVE_CIPHER_ASSERT_SVH
`define REPEATING_KEY_ADDITIVE_CIPHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RKAC_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RKAC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/rkac_pkg.sv @@
package rkac_pkg;

    localparam int MSG_DEPTH_DEF = 64;
    localparam int KEY_DEPTH_DEF = 32;

    localparam int BYTE_W      = 8;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_BYTES   = 32;
    localparam int KEY_LEN_W   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MULT_FACTOR = 5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0_7   = 3'd0,
        CFG_KEY_8_15  = 3'd1,
        CFG_KEY_16_23 = 3'd2,
        CFG_KEY_24_31 = 3'd3,
        CFG_KEY_LEN   = 3'd4,
        CFG_DECRYPT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_LEN_W-1:0] key_length;
        logic                 decrypt;
    } t_key_cfg;

endpackage

@@ rtl/core/repeating_key_additive_cipher.sv @@
// Repeating-key additive byte cipher. Message bytes arrive on the slave stream, one per
// cycle while the block is loading, and are written into an on-chip message buffer of
// MESSAGE_DEPTH bytes; bytes that arrive once the buffer is full are dropped, and every
// result of that message then carries the overflow flag in m_axis_tuser. The byte marked by
// s_axis_tlast closes the message (it closes it even when it is dropped). With P stored
// bytes and K key bytes in use, the block then runs max(P,K)+1 steps; step t adds
// key[t mod K] times a multiplier, modulo 256, to buffer entry t mod P. The multiplier is
// 5*K mod 256 to encrypt and its negation to decrypt. A key length of zero leaves the
// message unchanged, and a key length above KEY_DEPTH is treated as KEY_DEPTH. The P bytes
// then leave on the master stream in order, the last one marked by m_axis_tlast. Each step
// is a read-modify-write of the buffer memory, a read state and then a write state, because
// the write of one step must land before the next step may read the same entry (a one-byte
// message hits one entry on every step). Output first primes the memory read and then hands
// out one byte at a time while the sink is ready. The output register holds the last result
// so that loading of the next message can start while it still waits. The key registers and
// mode are to be written over the configuration port only while the block is idle; the
// block itself does not enforce this. The key length and mode present when the closing byte
// arrives are used; the key bytes are read as the steps run.
`include "repeating_key_additive_cipher_assert.svh"

module repeating_key_additive_cipher #(
    parameter int MESSAGE_DEPTH = rkac_pkg::MSG_DEPTH_DEF,
    parameter int KEY_DEPTH     = rkac_pkg::KEY_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [rkac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rkac_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rkac_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] message_byte
    input  logic                            s_axis_tlast,   // final_byte
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rkac_pkg::BYTE_W-1:0]     m_axis_tdata,   // [7:0] result_byte
    output logic                            m_axis_tlast,   // end_of_message
    output logic                            m_axis_tuser    // [0] overflow_seen
);
    import rkac_pkg::*;

    localparam int AW    = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int CW    = $clog2(MESSAGE_DEPTH + 1);
    localparam int KW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int MAXPK = (MESSAGE_DEPTH > KEY_DEPTH) ? MESSAGE_DEPTH : KEY_DEPTH;
    localparam int SW    = $clog2(MAXPK + 2);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PROC_RD,
        ST_PROC_WR,
        ST_EMIT_FETCH,
        ST_EMIT
    } t_state;

    t_state r_state;

    // Message bookkeeping.
    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic [CW-1:0]        r_p;
    logic [KEY_LEN_W-1:0] r_k;
    logic [BYTE_W-1:0]    r_mult;
    logic [SW-1:0]        r_steps;
    logic [AW-1:0]        r_idx;
    logic [KW-1:0]        r_kidx;
    logic [AW-1:0]        r_emit;

    // Output register.
    logic                 r_m_valid;
    logic [BYTE_W-1:0]    r_m_data;
    logic                 r_m_last;
    logic                 r_m_ovf;

    // Key registers.
    logic [KEY_BYTES-1:0][BYTE_W-1:0] key_bytes;
    t_key_cfg                         key_cfg;

    // Memory port signals.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [BYTE_W-1:0]    ram_rdata;

    logic                 in_acc;
    logic                 store_ok;
    logic [CW-1:0]        n_p;
    logic [KEY_LEN_W-1:0] n_k;
    logic [BYTE_W-1:0]    n_mult;
    logic [SW-1:0]        n_steps;
    logic [BYTE_W-1:0]    key_sel;
    logic [2*BYTE_W-1:0]  prod;
    logic                 idx_wrap;
    logic                 kidx_wrap;
    logic                 emit_last;
    logic                 out_load;

    rkac_key_regs u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_key_bytes (key_bytes),
        .o_key_cfg   (key_cfg)
    );

    rkac_msg_ram #(
        .DEPTH (MESSAGE_DEPTH),
        .AW    (AW)
    ) u_msg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign store_ok      = (r_count < CW'(MESSAGE_DEPTH));

    // Message parameters captured when the closing byte arrives.
    assign n_p = store_ok ? r_count + CW'(1) : r_count;
    assign n_k = (key_cfg.key_length > KEY_LEN_W'(KEY_DEPTH)) ? KEY_LEN_W'(KEY_DEPTH)
                                                              : key_cfg.key_length;

    always_comb begin
        logic [BYTE_W-1:0] mult_enc;
        mult_enc = BYTE_W'({2'b00, n_k} * BYTE_W'(MULT_FACTOR));
        n_mult   = key_cfg.decrypt ? BYTE_W'(0) - mult_enc : mult_enc;
    end

    assign n_steps = ((SW'(n_p) > SW'(n_k)) ? SW'(n_p) : SW'(n_k)) + SW'(1);

    // One step adds the selected key byte times the multiplier to one buffer byte.
    assign key_sel   = key_bytes[5'(r_kidx)];
    assign prod      = key_sel * r_mult;
    assign idx_wrap  = (CW'(r_idx) + CW'(1) == r_p);
    assign kidx_wrap = (KEY_LEN_W'(r_kidx) + KEY_LEN_W'(1) == r_k);

    assign emit_last = (CW'(r_emit) + CW'(1) == r_p);
    assign out_load  = (r_state == ST_EMIT) && (!r_m_valid || m_axis_tready);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata + prod[BYTE_W-1:0];
        ram_raddr = r_idx;
        unique case (r_state)
            ST_LOAD: begin
                ram_we    = in_acc && store_ok;
                ram_waddr = r_count[AW-1:0];
                ram_wdata = s_axis_tdata;
            end
            ST_PROC_RD: begin
                ram_raddr = r_idx;
            end
            ST_PROC_WR: begin
                ram_we = 1'b1;
            end
            ST_EMIT_FETCH: begin
                ram_raddr = '0;
            end
            ST_EMIT: begin
                // Fetch the next byte while the current one moves to the output.
                ram_raddr = out_load ? r_emit + AW'(1) : r_emit;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
                r_m_data  <= ram_rdata;
                r_m_last  <= emit_last;
                r_m_ovf   <= r_ovf;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (store_ok) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_p     <= n_p;
                            r_k     <= n_k;
                            r_mult  <= n_mult;
                            r_steps <= n_steps;
                            r_idx   <= '0;
                            r_kidx  <= '0;
                            if (n_k != '0 && n_p != '0) begin
                                r_state <= ST_PROC_RD;
                            end else begin
                                r_state <= ST_EMIT_FETCH;
                            end
                        end
                    end
                end
                ST_PROC_RD: begin
                    r_state <= ST_PROC_WR;
                end
                ST_PROC_WR: begin
                    r_idx   <= idx_wrap ? '0 : r_idx + AW'(1);
                    r_kidx  <= kidx_wrap ? '0 : r_kidx + KW'(1);
                    r_steps <= r_steps - SW'(1);
                    if (r_steps == SW'(1)) begin
                        r_state <= ST_EMIT_FETCH;
                    end else begin
                        r_state <= ST_PROC_RD;
                    end
                end
                ST_EMIT_FETCH: begin
                    r_emit  <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_load) begin
                        if (emit_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_emit <= r_emit + AW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_ovf;

    // A stored byte must advance the fill count by exactly one.
    `RKAC_ASSERT_NEXT(a_count_step, in_acc && store_ok,
        r_count == $past(r_count) + CW'(1), "fill count did not advance on a stored byte")

    // Step indexes must stay inside the message and the key.
    `RKAC_ASSERT_SAME(a_step_range, r_state == ST_PROC_WR,
        (CW'(r_idx) < r_p) && (KEY_LEN_W'(r_kidx) < r_k), "step index outside message or key")

    // Handing out the last result must leave an empty buffer with the flag clear.
    `RKAC_ASSERT_NEXT(a_emit_clear, out_load && emit_last,
        (r_count == '0) && !r_ovf && r_m_last, "buffer not cleared after last result")

endmodule

@@ rtl/core/rkac_key_regs.sv @@
module rkac_key_regs (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_wr_en,
    input  logic [rkac_pkg::CFG_IDX_W-1:0]                 i_cfg_index,
    input  logic [rkac_pkg::CFG_DATA_W-1:0]                i_cfg_wdata,
    output logic [rkac_pkg::KEY_BYTES-1:0][rkac_pkg::BYTE_W-1:0] o_key_bytes,
    output rkac_pkg::t_key_cfg                             o_key_cfg
);
    import rkac_pkg::*;

    logic [KEY_WORDS-1:0][CFG_DATA_W-1:0] r_key;
    t_key_cfg                             r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KEY_0_7:   r_key[0] <= i_cfg_wdata;
                CFG_KEY_8_15:  r_key[1] <= i_cfg_wdata;
                CFG_KEY_16_23: r_key[2] <= i_cfg_wdata;
                CFG_KEY_24_31: r_key[3] <= i_cfg_wdata;
                CFG_KEY_LEN:   r_cfg.key_length <= i_cfg_wdata[KEY_LEN_W-1:0];
                CFG_DECRYPT:   r_cfg.decrypt <= i_cfg_wdata[0];
                default: begin
                    // Unused indexes are ignored.
                end
            endcase
        end
    end

    // Byte 0 of the key sits in the lowest bits of the first word.
    assign o_key_bytes = r_key;
    assign o_key_cfg   = r_cfg;

endmodule

@@ rtl/core/rkac_msg_ram.sv @@
module rkac_msg_ram #(
    parameter int DEPTH = rkac_pkg::MSG_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [rkac_pkg::BYTE_W-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [rkac_pkg::BYTE_W-1:0] o_rd_data
);
    import rkac_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // One write port and one read port; read data is registered and appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the repeating-key additive cipher.
//
// Message bytes are queued by the stimulus sequence and offered on the slave stream by a
// bursty driver. Every accepted request is fed to a behavioral predictor, which mirrors the
// message buffer, the key registers and the mode. When a closing byte is taken, the
// predictor computes the whole transformed message and queues one expected result per
// stored byte. The monitor pops one expectation for each result request taken on the master
// stream and compares all three fields. The sink throttles tready on a pattern of its own.
module tb;
    import rkac_pkg::*;

    localparam int MESSAGE_DEPTH  = MSG_DEPTH_DEF;
    localparam int KEY_DEPTH      = KEY_DEPTH_DEF;
    localparam int RESET_CYCLES   = 12;
    // Once the last byte of a message is out the block is idle, so a short settle is enough
    // before a write.
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_ITEMS   = 430;
    localparam int TIMEOUT_UNITS  = 3000000;

    // Indexes that no register answers to; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_msg_byte;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
    } t_cipher_byte;

    // Clock, reset and all block inputs start at known values.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    repeating_key_additive_cipher #(
        .MESSAGE_DEPTH (MESSAGE_DEPTH),
        .KEY_DEPTH     (KEY_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] message_byte
        .s_axis_tlast  (s_axis_tlast),   // final_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] result_byte
        .m_axis_tlast  (m_axis_tlast),   // end_of_message
        .m_axis_tuser  (m_axis_tuser)    // [0] overflow_seen
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bytes waiting to be offered, and transformed bytes waiting to come out.
    t_msg_byte    msg_in_q[$];
    t_cipher_byte cipher_out_q[$];

    int err_count  = 0;
    int items_sent = 0;

    // Shadow copy of the configuration registers.
    logic [CFG_DATA_W-1:0] key_word [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  key_len  = '0;
    logic                  decrypt  = 1'b0;

    // Shadow copy of the message buffer.
    logic [BYTE_W-1:0] msg_buf [MESSAGE_DEPTH];
    int                msg_len  = 0;
    logic              ovf_flag = 1'b0;

    initial begin
        for (int w = 0; w < KEY_WORDS; w++) begin
            key_word[w] = '0;
        end
    end

    // Take one accepted byte into the shadow buffer. On the closing byte, run the key walk
    // over the buffer and queue the whole transformed message.
    function automatic void absorb_byte(logic [BYTE_W-1:0] b, logic fin);
        int                p;
        int                k;
        int                steps;
        int                i;
        int                j;
        logic [BYTE_W-1:0] mult;
        logic [BYTE_W-1:0] kb;
        t_cipher_byte      r;
        if (msg_len < MESSAGE_DEPTH) begin
            msg_buf[msg_len] = b;
            msg_len++;
        end else begin
            // Full buffer: the byte is lost, but a closing byte still ends the message.
            ovf_flag = 1'b1;
        end
        if (!fin) begin
            return;
        end
        p = msg_len;
        k = (int'(key_len) > KEY_DEPTH) ? KEY_DEPTH : int'(key_len);
        mult = 8'(MULT_FACTOR * k);
        if (decrypt) begin
            mult = -mult;
        end
        // A zero key length leaves the buffer untouched.
        if (k != 0 && p != 0) begin
            steps = ((p > k) ? p : k) + 1;
            i = 0;
            j = 0;
            for (int t = 0; t < steps; t++) begin
                if (j >= k) begin
                    j = 0;
                end
                if (i >= p) begin
                    i = 0;
                end
                kb = key_word[j >> 3][(j & 7) * 8 +: 8];
                msg_buf[i] = msg_buf[i] + 8'(kb * mult);
                i++;
                j++;
            end
        end
        for (int n = 0; n < p; n++) begin
            r.data = msg_buf[n];
            r.last = (n + 1 == p);
            r.ovf  = ovf_flag;
            cipher_out_q.push_back(r);
        end
        msg_len  = 0;
        ovf_flag = 1'b0;
    endfunction

    // Set when the previous rising edge took a request, so the driver knows it may move on.
    logic in_taken = 1'b0;

    // Sample both streams at the rising edge; inputs only move on the falling edge.
    always @(posedge i_clk) begin
        t_cipher_byte exp_b;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            absorb_byte(s_axis_tdata, s_axis_tlast);
            void'(msg_in_q.pop_front());
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_out_q.size() == 0) begin
                $error("unexpected result request: result_byte %0h", m_axis_tdata);
                err_count++;
            end else begin
                exp_b = cipher_out_q.pop_front();
                if (m_axis_tdata !== exp_b.data) begin
                    $error("result_byte: expected %0h, actual %0h", exp_b.data, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== exp_b.last) begin
                    $error("end_of_message: expected %0b, actual %0b",
                           exp_b.last, m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tuser !== exp_b.ovf) begin
                    $error("overflow_seen: expected %0b, actual %0b", exp_b.ovf, m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    // Source side: bursts of back-to-back requests separated by random gaps. A request that
    // has not been taken yet is held unchanged.
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!(s_axis_tvalid && !in_taken)) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (msg_in_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= msg_in_q[0].data;
                s_axis_tlast  <= msg_in_q[0].last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    // Four bursts in ten run straight into the next one.
                    gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: tready follows one of several patterns, each held for a random stretch:
    // always ready, coin flip, mostly stalled, or a fixed duty cycle.
    int         seg_left = 0;
    int         rdy_mode = 0;
    logic [2:0] pat_cnt  = '0;

    always @(negedge i_clk) begin
        pat_cnt <= pat_cnt + 1'b1;
        if (seg_left == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            seg_left <= $urandom_range(20, 200);
        end else begin
            seg_left <= seg_left - 1;
        end
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (pat_cnt < 3'd3);
        endcase
    end

    // One register write, mirrored into the shadow configuration. Writes to unused indexes
    // must be ignored by the block, so the shadow ignores them too.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_KEY_0_7, CFG_KEY_8_15, CFG_KEY_16_23, CFG_KEY_24_31: key_word[idx[1:0]] = val;
            CFG_KEY_LEN: key_len = val[KEY_LEN_W-1:0];
            CFG_DECRYPT: decrypt = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic add_item(logic [BYTE_W-1:0] b, logic fin);
        t_msg_byte m;
        m.data = b;
        m.last = fin;
        msg_in_q.push_back(m);
        items_sent++;
    endtask

    task automatic queue_message(int len);
        for (int n = 0; n < len; n++) begin
            add_item(8'($urandom), n == len - 1);
        end
    endtask

    // Wait until every byte has been taken and every result has come out, then let the
    // block settle before the configuration may change.
    task automatic drain_and_settle();
        do begin
            @(negedge i_clk);
        end while (msg_in_q.size() != 0 || cipher_out_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // A fresh random setting; key lengths favor the edges: zero, one, exactly the key depth,
    // and values beyond it that must saturate. Upper bits of the narrow registers are junk.
    task automatic random_config();
        int                   pick;
        logic [KEY_LEN_W-1:0] klen;
        logic [CFG_DATA_W-1:0] w;
        for (int n = 0; n < KEY_WORDS; n++) begin
            pick = $urandom_range(0, 9);
            w = (pick == 0) ? '1 : ((pick == 1) ? '0 : rand_word());
            write_cfg(CFG_IDX_W'(n), w);
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0: klen = 6'd0;
            1: klen = 6'd1;
            2: klen = 6'(KEY_DEPTH);
            3: klen = 6'($urandom_range(KEY_DEPTH + 1, 63));
            default: klen = 6'($urandom_range(2, KEY_DEPTH - 1));
        endcase
        w = rand_word();
        write_cfg(CFG_KEY_LEN, {w[CFG_DATA_W-1:KEY_LEN_W], klen});
        w = rand_word();
        write_cfg(CFG_DECRYPT, w);
        if ($urandom_range(0, 4) == 0) begin
            write_cfg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, rand_word());
        end
    endtask

    initial begin
        int pick;
        int n_msgs;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers straight out of reset: zero key length, so bytes come back unchanged.
        @(posedge i_clk);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h5A, 1'b1);
        drain_and_settle();

        // One-byte key of all ones against a one-byte message, then a message longer
        // than the key.
        write_cfg(CFG_KEY_0_7, '1);
        write_cfg(CFG_KEY_LEN, 64'd1);
        @(posedge i_clk);
        add_item(8'hFF, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b1);
        drain_and_settle();

        // Full-depth key in decrypt mode, longer than the message.
        write_cfg(CFG_KEY_8_15, rand_word());
        write_cfg(CFG_KEY_16_23, rand_word());
        write_cfg(CFG_KEY_24_31, '1);
        write_cfg(CFG_KEY_LEN, 64'(KEY_DEPTH));
        write_cfg(CFG_DECRYPT, 64'd1);
        @(posedge i_clk);
        queue_message(3);
        drain_and_settle();

        // Key length at its field maximum must saturate; the spare index must do nothing.
        write_cfg(CFG_KEY_LEN, '1);
        write_cfg(CFG_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE);
        write_cfg(CFG_SPARE_7, '1);
        @(posedge i_clk);
        queue_message(4);
        drain_and_settle();

        // Just beyond the key depth, decrypting a single byte.
        write_cfg(CFG_KEY_0_7, 64'h0);
        write_cfg(CFG_KEY_LEN, 64'(KEY_DEPTH + 1));
        write_cfg(CFG_DECRYPT, 64'd1);
        @(posedge i_clk);
        add_item(8'hA5, 1'b1);
        drain_and_settle();

        // Random part: phases of a few messages each under a new setting. Most messages
        // are short; some fill the buffer exactly and some run past it.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            random_config();
            @(posedge i_clk);
            n_msgs = $urandom_range(1, 4);
            for (int m = 0; m < n_msgs; m++) begin
                pick = $urandom_range(0, 19);
                case (pick)
                    0: queue_message(MESSAGE_DEPTH);
                    1: queue_message($urandom_range(MESSAGE_DEPTH + 1, MESSAGE_DEPTH + 4));
                    2: queue_message($urandom_range(40, MESSAGE_DEPTH - 1));
                    default: queue_message($urandom_range(1, 12));
                endcase
            end
            drain_and_settle();
        end

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(TIMEOUT_UNITS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rkac_pkg.sv
rtl/core/rkac_key_regs.sv
rtl/core/rkac_msg_ram.sv
rtl/core/repeating_key_additive_cipher.sv
bench/tb.sv
